@@ rtl/core/kmdr_pkg.sv @@
// Package for the key matrix debounce and report unit.
// Holds field widths, constants, request codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package kmdr_pkg;

  localparam int unsigned NUM_ROWS_DEF    = 5;
  localparam int unsigned NUM_COLS_DEF    = 8;
  localparam int unsigned REPORT_KEYS_DEF = 6;

  localparam int unsigned SCAN_W      = 40;
  localparam int unsigned ROW_STRIDE  = 8;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SLOTS       = 6;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [BYTE_W-1:0] FN_MARK    = 8'hFF;
  localparam logic [BYTE_W-1:0] THRESH_RST = 8'd3;

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_MAP  = 1'b1;

  typedef struct packed {
    logic map_we;
    logic deb_en;
    logic acc_clr;
    logic rd_en;
    logic pass_map;
    logic out_load;
  } kmdr_cmd_t;

  typedef struct packed {
    logic changed;
    logic key_last;
  } kmdr_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/kmdr_datapath.sv @@
// Datapath: row debounce registers, keymap memory, report accumulators, output register.
// Depends on kmdr_pkg; driven by kmdr_ctrl through kmdr_cmd_t.
`default_nettype none

module kmdr_datapath #(
  parameter int unsigned NUM_ROWS    = kmdr_pkg::NUM_ROWS_DEF,
  parameter int unsigned NUM_COLS    = kmdr_pkg::NUM_COLS_DEF,
  parameter int unsigned REPORT_KEYS = kmdr_pkg::REPORT_KEYS_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire kmdr_pkg::kmdr_cmd_t                           cmd_i,
  output kmdr_pkg::kmdr_sts_t                                sts_o,
  input  wire logic                                          cfg_we_i,
  input  wire logic [kmdr_pkg::BYTE_W-1:0]                   cfg_wdata_i,
  input  wire logic [kmdr_pkg::SCAN_W-1:0]                   scan_bits_i,
  input  wire logic                                          map_layer_i,
  input  wire logic [kmdr_pkg::IDX_W-1:0]                    map_index_i,
  input  wire logic [kmdr_pkg::BYTE_W-1:0]                   map_modifier_i,
  input  wire logic [kmdr_pkg::BYTE_W-1:0]                   map_code_i,
  output logic [kmdr_pkg::BYTE_W-1:0]                        modifier_byte_o,
  output logic [kmdr_pkg::SLOTS-1:0][kmdr_pkg::BYTE_W-1:0]   key_codes_o,
  output logic [kmdr_pkg::CNT_W-1:0]                         codes_reported_o
);
  import kmdr_pkg::*;

  localparam int unsigned KEYS  = NUM_ROWS * NUM_COLS;
  localparam int unsigned KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int unsigned ADDR_W = KEY_W + 1;
  localparam int unsigned DEPTH = 2 ** ADDR_W;
  localparam int unsigned ENTRY_W = 2 * BYTE_W;

  logic [BYTE_W-1:0]   thr_q;
  logic [NUM_COLS-1:0] stable_q [NUM_ROWS];
  logic [NUM_COLS-1:0] stable_d [NUM_ROWS];
  logic [NUM_COLS-1:0] cand_q   [NUM_ROWS];
  logic [NUM_COLS-1:0] cand_d   [NUM_ROWS];
  logic [BYTE_W-1:0]   agree_q  [NUM_ROWS];
  logic [BYTE_W-1:0]   agree_d  [NUM_ROWS];
  logic [NUM_COLS-1:0] raw_row  [NUM_ROWS];
  logic [KEYS-1:0]     stable_keys;
  logic                changed;

  logic [ENTRY_W-1:0]  keymap_mem [DEPTH];
  logic [ENTRY_W-1:0]  rdata_q;
  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   waddr;
  logic                map_in_range;

  logic [KEY_W-1:0]    key_q;
  logic                key_last;
  logic                rd_vld_q;
  logic                press_q;
  logic                pass_q;

  logic                           fn_q;
  logic [BYTE_W-1:0]              mod_q;
  logic [CNT_W-1:0]               filled_q;
  logic [SLOTS-1:0][BYTE_W-1:0]   codes_q;
  logic [BYTE_W-1:0]              rd_mod;
  logic [BYTE_W-1:0]              rd_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      raw_row[r] = '0;
      for (int c = 0; c < NUM_COLS; c++) begin
        if (r * ROW_STRIDE + c < SCAN_W) begin
          raw_row[r][c] = scan_bits_i[r * ROW_STRIDE + c];
        end
      end
    end
  end

  always_comb begin
    changed = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      stable_d[r] = stable_q[r];
      cand_d[r]   = cand_q[r];
      agree_d[r]  = agree_q[r];
      if (raw_row[r] == cand_q[r]) begin
        if (agree_q[r] < thr_q) begin
          agree_d[r] = agree_q[r] + 8'd1;
        end
        if (agree_d[r] >= thr_q && stable_q[r] != raw_row[r]) begin
          stable_d[r] = raw_row[r];
          changed     = 1'b1;
        end
      end else begin
        cand_d[r]  = raw_row[r];
        agree_d[r] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        stable_q[r] <= '0;
        cand_q[r]   <= '0;
        agree_q[r]  <= '0;
      end
    end else if (cmd_i.deb_en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        stable_q[r] <= stable_d[r];
        cand_q[r]   <= cand_d[r];
        agree_q[r]  <= agree_d[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        stable_keys[r * NUM_COLS + c] = stable_q[r][c];
      end
    end
  end

  assign map_in_range = {1'b0, map_index_i} < (IDX_W + 1)'(KEYS);
  assign waddr        = {map_layer_i, map_index_i[KEY_W-1:0]};
  assign raddr        = {cmd_i.pass_map & fn_q, key_q};
  assign key_last     = key_q == KEY_W'(KEYS - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_we && map_in_range) begin
      keymap_mem[waddr] <= {map_modifier_i, map_code_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= keymap_mem[raddr];
      press_q <= stable_keys[key_q];
      pass_q  <= cmd_i.pass_map;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        key_q <= key_last ? '0 : key_q + KEY_W'(1);
      end
    end
  end

  assign rd_mod  = rdata_q[ENTRY_W-1:BYTE_W];
  assign rd_code = rdata_q[BYTE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q     <= 1'b0;
      mod_q    <= '0;
      filled_q <= '0;
      codes_q  <= '0;
    end else if (cmd_i.acc_clr) begin
      fn_q     <= 1'b0;
      mod_q    <= '0;
      filled_q <= '0;
      codes_q  <= '0;
    end else if (rd_vld_q && press_q) begin
      if (!pass_q) begin
        if (rd_mod == FN_MARK && rd_code == '0) begin
          fn_q <= 1'b1;
        end
      end else begin
        if (rd_mod != FN_MARK) begin
          mod_q <= mod_q + rd_mod;
        end
        if (filled_q < CNT_W'(REPORT_KEYS) && rd_code != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (filled_q == CNT_W'(i)) begin
              codes_q[i] <= rd_code;
            end
          end
          filled_q <= filled_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      modifier_byte_o  <= mod_q;
      key_codes_o      <= codes_q;
      codes_reported_o <= filled_q;
    end
  end

  assign sts_o.changed  = changed;
  assign sts_o.key_last = key_last;

endmodule

`default_nettype wire

@@ rtl/core/kmdr_ctrl.sv @@
// Controller state machine: request handshake, two keymap passes, result handshake.
// Depends on kmdr_pkg; commands kmdr_datapath.
`default_nettype none

module kmdr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 req_type_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output kmdr_pkg::kmdr_cmd_t       cmd_o,
  input  wire kmdr_pkg::kmdr_sts_t  sts_i
);
  import kmdr_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FN      = 3'd1;
  localparam logic [2:0] ST_FN_END  = 3'd2;
  localparam logic [2:0] ST_MAP     = 3'd3;
  localparam logic [2:0] ST_MAP_END = 3'd4;
  localparam logic [2:0] ST_REPORT  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_vld_q;
  logic       accept;

  assign in_ready_o  = state_q == ST_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_MAP) begin
            cmd_o.map_we = 1'b1;
          end else begin
            cmd_o.deb_en  = 1'b1;
            cmd_o.acc_clr = 1'b1;
            if (sts_i.changed) begin
              state_d = ST_FN;
            end
          end
        end
      end
      ST_FN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.key_last) begin
          state_d = ST_FN_END;
        end
      end
      ST_FN_END: begin
        state_d = ST_MAP;
      end
      ST_MAP: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.pass_map = 1'b1;
        if (sts_i.key_last) begin
          state_d = ST_MAP_END;
        end
      end
      ST_MAP_END: begin
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/key_matrix_debounce_report_unit.sv @@
// Top level of the key matrix debounce and keyboard report unit.
// Depends on kmdr_pkg, kmdr_ctrl and kmdr_datapath.
`default_nettype none

// Takes scan ticks (tuser 0) and keymap writes (tuser 1) one at a time. A keymap
// write or a scan tick that changes no debounced row leaves the unit idle. A scan
// tick that changes a debounced row walks the keymap memory twice through its
// single read port, one key per cycle, once to find a held Fn key and once to build
// the report. The report is then loaded into the output register and the unit
// returns to idle; a report still held unaccepted in the output register stalls
// that load. A finished report waits in the output register while the next
// request is taken. The keymap has no reset; load every entry that a pressed key
// can reach before scanning.
module key_matrix_debounce_report_unit #(
  parameter int unsigned NUM_ROWS    = kmdr_pkg::NUM_ROWS_DEF,
  parameter int unsigned NUM_COLS    = kmdr_pkg::NUM_COLS_DEF,
  parameter int unsigned REPORT_KEYS = kmdr_pkg::REPORT_KEYS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [kmdr_pkg::BYTE_W-1:0]         cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // scan_bits[39:0], map_layer[40], map_index[46:41], map_modifier[54:47],
  // map_code[62:55], zero[63]
  input  wire logic [kmdr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type[0]
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // modifier_byte[7:0], key_code_a[15:8] .. key_code_f[55:48],
  // codes_reported[58:56], zero[63:59]
  output logic [kmdr_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
  import kmdr_pkg::*;

  kmdr_cmd_t                   cmd;
  kmdr_sts_t                   sts;
  logic [BYTE_W-1:0]           modifier_byte;
  logic [SLOTS-1:0][BYTE_W-1:0] key_codes;
  logic [CNT_W-1:0]            codes_reported;

  kmdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kmdr_datapath #(
    .NUM_ROWS    (NUM_ROWS),
    .NUM_COLS    (NUM_COLS),
    .REPORT_KEYS (REPORT_KEYS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .scan_bits_i      (s_axis_tdata[39:0]),
    .map_layer_i      (s_axis_tdata[40]),
    .map_index_i      (s_axis_tdata[46:41]),
    .map_modifier_i   (s_axis_tdata[54:47]),
    .map_code_i       (s_axis_tdata[62:55]),
    .modifier_byte_o  (modifier_byte),
    .key_codes_o      (key_codes),
    .codes_reported_o (codes_reported)
  );

  assign m_axis_tdata = {5'b0, codes_reported, key_codes, modifier_byte};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[58:56] <= CNT_W'(REPORT_KEYS))
    else $error("report count exceeds slot limit");

  a_empty_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[58:56] == '0) |-> m_axis_tdata[55:8] == '0)
    else $error("empty report carries key codes");

  a_quiet_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_SCAN && !sts.changed)
      |=> s_axis_tready)
    else $error("scan without stable change left the unit busy");

  a_map_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_MAP) |=> s_axis_tready)
    else $error("keymap write left the unit busy");

endmodule

`default_nettype wire
